// ===== hw/rtl/nsc_pkg.sv =====
// Package for the NMEA sentence checker: byte codes, sentence types, result struct.
// Used by nsc_frame_tracker and nmea_sentence_checker; depends on nothing.
package nsc_pkg;

  localparam int MAX_SENTENCE_LEN = 128;
  localparam int POS_W            = $clog2(MAX_SENTENCE_LEN);
  localparam int NUM_TYPES        = 3;
  localparam int TYPE_LEN         = 5;

  localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_SENTENCE_LEN - 1);
  localparam logic [POS_W-1:0] POS_TYPE_END = POS_W'(TYPE_LEN);

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_NUL    = 8'h00;

  typedef enum logic [1:0] {
    TYPE_GNRMC = 2'd0,
    TYPE_GPGSA = 2'd1,
    TYPE_GNGGA = 2'd2
  } nsc_type_t;

  // Type letters, one row per sentence type in type-code order.
  localparam logic [7:0] TYPE_TEXT [NUM_TYPES][TYPE_LEN] = '{
    '{8'h47, 8'h4E, 8'h52, 8'h4D, 8'h43},  // G N R M C
    '{8'h47, 8'h50, 8'h47, 8'h53, 8'h41},  // G P G S A
    '{8'h47, 8'h4E, 8'h47, 8'h47, 8'h41}   // G N G G A
  };

  typedef struct packed {
    nsc_type_t  sentence_type;
    logic       checksum_ok;
    logic [7:0] computed_sum;
    logic [6:0] sentence_length;
  } nsc_result_t;

  // Hex digit value, or -1 for anything else.
  function automatic logic signed [4:0] hex_value(input logic [7:0] c);
    logic signed [4:0] v;
    v = -5'sd1;
    if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
    else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h41 + 8'd10);
    else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h61 + 8'd10);
    return v;
  endfunction

endpackage

// ===== hw/rtl/nsc_frame_tracker.sv =====
// Sentence state and per-byte update logic of the NMEA sentence checker.
// Depends on nsc_pkg for byte codes, type table and the result struct.
module nsc_frame_tracker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  logic [7:0]          step_byte,
  output logic                res_valid,
  output nsc_pkg::nsc_result_t res
);

  logic                      in_sentence_r, in_sentence_nxt;
  logic [nsc_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [2:0]                flags_r, flags_nxt;
  logic [7:0]                xor_r, xor_nxt;
  logic                      star_r, star_nxt;
  logic                      zero_r, zero_nxt;
  logic [1:0]                ndig_r, ndig_nxt;
  logic signed [4:0]         d1_r, d1_nxt;
  logic signed [4:0]         d2_r, d2_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_sentence_r <= 1'b0;
      pos_r         <= '0;
      flags_r       <= 3'b111;
      xor_r         <= '0;
      star_r        <= 1'b0;
      zero_r        <= 1'b0;
      ndig_r        <= '0;
      d1_r          <= -5'sd1;
      d2_r          <= -5'sd1;
    end else begin
      in_sentence_r <= in_sentence_nxt;
      pos_r         <= pos_nxt;
      flags_r       <= flags_nxt;
      xor_r         <= xor_nxt;
      star_r        <= star_nxt;
      zero_r        <= zero_nxt;
      ndig_r        <= ndig_nxt;
      d1_r          <= d1_nxt;
      d2_r          <= d2_nxt;
    end
  end

  always_comb begin
    logic                      start, act, in_type, done;
    logic [nsc_pkg::POS_W-1:0] p;
    logic [2:0]                fl, idx;
    logic [7:0]                x;
    logic                      st, zb;
    logic [1:0]                nd;
    logic signed [4:0]         a, b;
    logic signed [9:0]         sent;

    in_sentence_nxt = in_sentence_r;
    pos_nxt   = pos_r;
    flags_nxt = flags_r;
    xor_nxt   = xor_r;
    star_nxt  = star_r;
    zero_nxt  = zero_r;
    ndig_nxt  = ndig_r;
    d1_nxt    = d1_r;
    d2_nxt    = d2_r;
    res_valid = 1'b0;
    res       = '0;

    // A dollar restarts the sentence with cleared state.
    start = (step_byte == nsc_pkg::CH_DOLLAR);
    act   = start || in_sentence_r;
    p     = start ? '0 : pos_r;
    fl    = start ? 3'b111 : flags_r;
    x     = start ? 8'h00 : xor_r;
    st    = start ? 1'b0 : star_r;
    zb    = start ? 1'b0 : zero_r;
    nd    = start ? 2'd0 : ndig_r;
    a     = start ? -5'sd1 : d1_r;
    b     = start ? -5'sd1 : d2_r;
    done  = 1'b0;
    idx   = 3'(p - 1'b1);
    in_type = (p != '0) && (p <= nsc_pkg::POS_TYPE_END);
    sent  = ($signed(10'(a)) <<< 4) + $signed(10'(b));

    if (step_en && act) begin
      // CR before the type letters are complete: discard.
      if (in_type && p != nsc_pkg::POS_TYPE_END && step_byte == nsc_pkg::CH_CR) begin
        done = 1'b1;
      end else begin
        if (in_type) begin
          for (int k = 0; k < nsc_pkg::NUM_TYPES; k++) begin
            if (nsc_pkg::TYPE_TEXT[k][idx] != step_byte) fl[k] = 1'b0;
          end
          if (p == nsc_pkg::POS_TYPE_END && fl == 3'b000) done = 1'b1;
        end
        if (!done && p >= nsc_pkg::POS_LAST) done = 1'b1;
        if (!done && step_byte == nsc_pkg::CH_CR) begin
          done      = 1'b1;
          res_valid = 1'b1;
          if (fl[0])      res.sentence_type = nsc_pkg::TYPE_GNRMC;
          else if (fl[1]) res.sentence_type = nsc_pkg::TYPE_GPGSA;
          else            res.sentence_type = nsc_pkg::TYPE_GNGGA;
          res.checksum_ok     = st && !zb && (sent == $signed({2'b00, x}));
          res.computed_sum    = x;
          res.sentence_length = 7'(p);
        end
        if (!done) begin
          if (p != '0) begin
            if (!st) begin
              if (step_byte == nsc_pkg::CH_STAR)     st = 1'b1;
              else if (step_byte == nsc_pkg::CH_NUL) zb = 1'b1;
              else                                   x  = x ^ step_byte;
            end else if (nd != 2'd2) begin
              if (nd == 2'd0) a = nsc_pkg::hex_value(step_byte);
              else            b = nsc_pkg::hex_value(step_byte);
              nd = nd + 2'd1;
            end
          end
          p = p + 1'b1;
        end
      end
      in_sentence_nxt = !done;
      pos_nxt   = p;
      flags_nxt = fl;
      xor_nxt   = x;
      star_nxt  = st;
      zero_nxt  = zb;
      ndig_nxt  = nd;
      d1_nxt    = a;
      d2_nxt    = b;
    end
  end

endmodule

// ===== hw/rtl/nmea_sentence_checker.sv =====
// Top level of the NMEA sentence checker: input byte register, sentence tracker, result register.
// Depends on nsc_pkg and nsc_frame_tracker.
//
//   channel   direction  handshake             payload
//   in_       request    in_valid / in_ready   in_rx_byte
//   out_      result     out_valid / out_ready out_sentence_type, out_checksum_ok,
//                                              out_computed_sum, out_sentence_length
//
// Flow: one byte per clock while the result slot is free or being read. A byte is held in the
// input register, then the tracker updates the sentence state and loads the result register,
// so out_valid rises once its CR has passed on from the input register into the result register.
// Reset: synchronous, active low; the block comes up idle, waiting for a dollar.
// Stalls: while a result waits unread, the input register still takes one more byte;
// only then does in_ready drop.
module nmea_sentence_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_sentence_type,
  output logic       out_checksum_ok,
  output logic [7:0] out_computed_sum,
  output logic [6:0] out_sentence_length
);

  logic                 s1_valid_r, s1_valid_nxt;
  logic [7:0]           s1_byte_r;
  logic                 out_valid_r, out_valid_nxt;
  nsc_pkg::nsc_result_t out_res_r;
  logic                 advance;
  logic                 step_en;
  logic                 res_valid;
  nsc_pkg::nsc_result_t res;

  // The byte in the input register moves on whenever the result slot is free
  // or is being emptied this cycle.
  assign advance  = !out_valid_r || out_ready;
  assign step_en  = s1_valid_r && advance;
  assign in_ready = !s1_valid_r || advance;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && in_ready) s1_valid_nxt = 1'b1;
    else if (advance)         s1_valid_nxt = 1'b0;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step_en && res_valid) out_valid_nxt = 1'b1;
    else if (out_ready)       out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: load on accept, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_byte_r <= in_rx_byte;
    if (step_en && res_valid) out_res_r <= res;
  end

  nsc_frame_tracker u_tracker (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .step_byte (s1_byte_r),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_valid           = out_valid_r;
  assign out_sentence_type   = out_res_r.sentence_type;
  assign out_checksum_ok     = out_res_r.checksum_ok;
  assign out_computed_sum    = out_res_r.computed_sum;
  assign out_sentence_length = out_res_r.sentence_length;

endmodule

// ===== dv/nmea_sentence_checker_test.sv =====
`timescale 1ns / 1ps
// Testbench for nmea_sentence_checker: byte-stream stimulus, sentence predictor and result scoreboard.
// Depends on nsc_pkg and the nmea_sentence_checker RTL; runs on its own.
module nmea_sentence_checker_test;

  localparam logic [7:0] CH_LF = 8'h0A;

  // Ways a generated sentence can end after its body.
  typedef enum {
    TAIL_GOOD,
    TAIL_BAD_SUM,
    TAIL_NO_STAR,
    TAIL_ONE_DIGIT,
    TAIL_BAD_DIGIT,
    TAIL_EXTRA
  } tail_kind_t;

  // Scoreboard: tracks the sentence state the block should hold, queues the
  // result each request should cause and checks results as they come out.
  class sentence_scoreboard;
    nsc_pkg::nsc_result_t pending_q[$];
    bit          active;
    int unsigned pos;
    logic [2:0]  candidates;
    logic [7:0]  xor_acc;
    bit          star;
    bit          zero_seen;
    int          ndig;
    int          d1;
    int          d2;
    int          errors;
    int          checked;
    int          live_bytes;
    int          total_bytes;

    function new();
      clear_sentence();
      active = 1'b0;
    endfunction

    function void clear_sentence();
      active     = 1'b1;
      pos        = 0;
      candidates = 3'b111;
      xor_acc    = 8'h00;
      star       = 1'b0;
      zero_seen  = 1'b0;
      ndig       = 0;
      d1         = -1;
      d2         = -1;
    endfunction

    function int digit_value(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      return -1;
    endfunction

    // Advance the sentence state by one accepted request byte.
    function void note_request(logic [7:0] c);
      int unsigned p;
      nsc_pkg::nsc_result_t r;
      int          sent;
      total_bytes++;
      if (c == nsc_pkg::CH_DOLLAR) clear_sentence();
      if (!active) return;
      live_bytes++;
      p = pos;
      // CR before the type letters are all in: drop silently
      if (p >= 1 && p < nsc_pkg::TYPE_LEN && c == nsc_pkg::CH_CR) begin
        active = 1'b0;
        return;
      end
      if (p >= 1 && p <= nsc_pkg::TYPE_LEN) begin
        for (int k = 0; k < nsc_pkg::NUM_TYPES; k++)
          if (nsc_pkg::TYPE_TEXT[k][p-1] != c) candidates[k] = 1'b0;
        if (p == nsc_pkg::TYPE_LEN && candidates == 3'b000) begin
          active = 1'b0;
          return;
        end
      end
      if (p >= nsc_pkg::MAX_SENTENCE_LEN - 1) begin
        active = 1'b0;
        return;
      end
      if (c == nsc_pkg::CH_CR) begin
        if (candidates[0])      r.sentence_type = nsc_pkg::TYPE_GNRMC;
        else if (candidates[1]) r.sentence_type = nsc_pkg::TYPE_GPGSA;
        else                    r.sentence_type = nsc_pkg::TYPE_GNGGA;
        sent              = d1 * 16 + d2;
        r.checksum_ok     = star && !zero_seen && (sent == int'(xor_acc));
        r.computed_sum    = xor_acc;
        r.sentence_length = 7'(p);
        pending_q.push_back(r);
        active = 1'b0;
        return;
      end
      if (p >= 1) begin
        if (!star) begin
          if (c == nsc_pkg::CH_STAR)     star = 1'b1;
          else if (c == nsc_pkg::CH_NUL) zero_seen = 1'b1;
          else                           xor_acc ^= c;
        end else if (ndig < 2) begin
          if (ndig == 0) d1 = digit_value(c);
          else           d2 = digit_value(c);
          ndig++;
        end
      end
      pos = p + 1;
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= 40) $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Compare one accepted result against the oldest expectation.
    task check_result(nsc_pkg::nsc_result_t got);
      nsc_pkg::nsc_result_t want;
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("result with no request waiting (type %0d sum %02h len %0d)",
                                  got.sentence_type, got.computed_sum, got.sentence_length));
        return;
      end
      want = pending_q.pop_front();
      checked++;
      if (got.sentence_type != want.sentence_type)
        report_mismatch($sformatf("sentence_type got %0d expected %0d",
                                  got.sentence_type, want.sentence_type));
      if (got.checksum_ok != want.checksum_ok)
        report_mismatch($sformatf("checksum_ok got %0b expected %0b",
                                  got.checksum_ok, want.checksum_ok));
      if (got.computed_sum != want.computed_sum)
        report_mismatch($sformatf("computed_sum got %02h expected %02h",
                                  got.computed_sum, want.computed_sum));
      if (got.sentence_length != want.sentence_length)
        report_mismatch($sformatf("sentence_length got %0d expected %0d",
                                  got.sentence_length, want.sentence_length));
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_sentence_type;
  logic       out_checksum_ok;
  logic [7:0] out_computed_sum;
  logic [6:0] out_sentence_length;

  sentence_scoreboard sb = new();

  logic [7:0] tx_q[$];   // bytes built but not yet sent
  int         burst_left = 0;

  nmea_sentence_checker i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_sentence_type   (out_sentence_type),
    .out_checksum_ok     (out_checksum_ok),
    .out_computed_sum    (out_computed_sum),
    .out_sentence_length (out_sentence_length)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Hard stop in case the handshake hangs.
  initial begin
    #5_000_000;
    $display("timeout: run did not finish");
    $display("** nmea_sentence_checker: FAILED **");
    $finish;
  end

  // Send one request byte. The sender works in bursts: when a burst runs out,
  // drop valid for a random gap, then start a new burst of random length.
  // Now and then a burst is long enough to give a stretch with no gaps.
  task automatic send_byte(input logic [7:0] b);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 400 : $urandom_range(1, 40);
    end
    burst_left--;
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    // Hold valid and payload until the block takes the request.
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(b);
  endtask

  task automatic send_queue();
    foreach (tx_q[i]) send_byte(tx_q[i]);
    tx_q.delete();
  endtask

  // Stop sending until every expected result has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) tx_q.push_back(s[i]);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    logic lower;
    lower = $urandom_range(0, 1);
    if (v < 10) return 8'("0") + 8'(v);
    return (lower ? 8'("a") : 8'("A")) + 8'(v) - 8'd10;
  endfunction

  // Body byte: mostly printable text, sometimes any byte with the high bit
  // in play; never a dollar, star or CR, since those steer the sentence.
  function automatic logic [7:0] body_byte();
    logic [7:0] b;
    do begin
      b = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 255))
                                      : 8'($urandom_range(8'h20, 8'h7E));
    end while (b == nsc_pkg::CH_DOLLAR || b == nsc_pkg::CH_STAR || b == nsc_pkg::CH_CR);
    return b;
  endfunction

  // A byte that is none of the hex digits, a dollar or a CR.
  function automatic logic [7:0] non_hex_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (b == nsc_pkg::CH_DOLLAR || b == nsc_pkg::CH_CR ||
               (b >= "0" && b <= "9") || (b >= "A" && b <= "F") || (b >= "a" && b <= "f"));
    return b;
  endfunction

  // Build one sentence into tx_q. kind below NUM_TYPES picks a kept type,
  // anything else gives a kept type with one letter changed.
  task automatic make_sentence(input int kind, input int body_len, input tail_kind_t tail,
                               input bit zero_in_body);
    int         start;
    int         row;
    int         bad_at;
    logic [7:0] ch;
    logic [7:0] chk;
    start = tx_q.size();
    tx_q.push_back(nsc_pkg::CH_DOLLAR);
    row    = (kind < nsc_pkg::NUM_TYPES) ? kind : $urandom_range(0, nsc_pkg::NUM_TYPES - 1);
    bad_at = (kind < nsc_pkg::NUM_TYPES) ? -1 : $urandom_range(0, nsc_pkg::TYPE_LEN - 1);
    for (int k = 0; k < nsc_pkg::TYPE_LEN; k++) begin
      ch = nsc_pkg::TYPE_TEXT[row][k];
      if (k == bad_at) begin
        do ch = 8'($urandom_range("A", "Z")); while (ch == nsc_pkg::TYPE_TEXT[row][k]);
      end
      tx_q.push_back(ch);
    end
    for (int i = 0; i < body_len; i++) tx_q.push_back(body_byte());
    if (zero_in_body) tx_q.push_back(nsc_pkg::CH_NUL);
    chk = 8'h00;
    for (int i = start + 1; i < tx_q.size(); i++) chk ^= tx_q[i];
    if (tail != TAIL_NO_STAR) tx_q.push_back(nsc_pkg::CH_STAR);
    case (tail)
      TAIL_GOOD, TAIL_EXTRA: begin
        tx_q.push_back(hex_char(chk[7:4]));
        tx_q.push_back(hex_char(chk[3:0]));
        if (tail == TAIL_EXTRA)
          repeat ($urandom_range(1, 3))
            tx_q.push_back($urandom_range(0, 2) == 0 ? nsc_pkg::CH_STAR : body_byte());
      end
      TAIL_BAD_SUM: begin
        chk ^= 8'($urandom_range(1, 255));
        tx_q.push_back(hex_char(chk[7:4]));
        tx_q.push_back(hex_char(chk[3:0]));
      end
      TAIL_ONE_DIGIT: tx_q.push_back(hex_char(chk[7:4]));
      TAIL_BAD_DIGIT: begin
        if ($urandom_range(0, 1)) begin
          tx_q.push_back(non_hex_byte());
          tx_q.push_back(hex_char(chk[3:0]));
        end else begin
          tx_q.push_back(hex_char(chk[7:4]));
          tx_q.push_back(non_hex_byte());
        end
      end
      default: ;
    endcase
    tx_q.push_back(nsc_pkg::CH_CR);
    if ($urandom_range(0, 1)) tx_q.push_back(CH_LF);
  endtask

  // Receiver: take results when ready is high. Ready follows a rotating
  // stall mask that is redrawn every so often, sometimes all clear.
  initial begin
    logic [15:0]          stall_mask;
    int                   cyc;
    nsc_pkg::nsc_result_t got;
    stall_mask = 16'h0000;
    cyc        = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got.sentence_type   = nsc_pkg::nsc_type_t'(out_sentence_type);
        got.checksum_ok     = out_checksum_ok;
        got.computed_sum    = out_computed_sum;
        got.sentence_length = out_sentence_length;
        sb.check_result(got);
      end
      cyc++;
      if (cyc % 97 == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_mask = 16'h0000;
          1:       stall_mask = 16'($urandom);
          2:       stall_mask = 16'hFFF0;
          default: stall_mask = 16'h5555;
        endcase
      end
      stall_mask = {stall_mask[14:0], stall_mask[15]};
      out_ready <= !stall_mask[0];
    end
  end

  // Stimulus: directed sentences first, then random traffic.
  initial begin
    int         sel;
    int         iter;
    int         spins;
    int         cut;
    tail_kind_t tail;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Idle bytes before any dollar, including the extremes of the byte.
    push_text("idle");
    tx_q.push_back(8'hFF);
    tx_q.push_back(nsc_pkg::CH_NUL);
    tx_q.push_back(nsc_pkg::CH_CR);
    tx_q.push_back(CH_LF);
    // Each kept type with a correct checksum, shortest sentence first.
    make_sentence(0, 0, TAIL_GOOD, 1'b0);
    make_sentence(1, 6, TAIL_GOOD, 1'b0);
    make_sentence(2, 6, TAIL_EXTRA, 1'b0);
    // Checksum failures: wrong sum, no star, zero byte, short or bad digits.
    make_sentence(0, 4, TAIL_BAD_SUM, 1'b0);
    make_sentence(1, 4, TAIL_NO_STAR, 1'b0);
    make_sentence(2, 4, TAIL_GOOD, 1'b1);
    make_sentence(0, 3, TAIL_ONE_DIGIT, 1'b0);
    make_sentence(1, 3, TAIL_BAD_DIGIT, 1'b0);
    // Unknown type, CR inside the type, CR right after the dollar.
    make_sentence(3, 3, TAIL_GOOD, 1'b0);
    push_text("$GN");
    tx_q.push_back(nsc_pkg::CH_CR);
    tx_q.push_back(nsc_pkg::CH_DOLLAR);
    tx_q.push_back(nsc_pkg::CH_CR);
    push_text("$GNRM");
    tx_q.push_back(nsc_pkg::CH_CR);
    // Dollar inside the body and after the star restarts the sentence.
    push_text("$GNRMC,12");
    make_sentence(1, 2, TAIL_GOOD, 1'b0);
    push_text("$GNGGA,1*4");
    make_sentence(2, 2, TAIL_GOOD, 1'b0);
    // Longest kept sentence, then one byte too long.
    make_sentence(0, 117, TAIL_GOOD, 1'b0);
    make_sentence(2, 118, TAIL_GOOD, 1'b0);
    send_queue();
    drain_results();

    // Random part: mostly well-formed sentences with random content, the
    // rest noise and broken sentences, until enough bytes have gone in.
    iter = 0;
    while (sb.total_bytes < 1550) begin
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        case ($urandom_range(0, 9))
          0:       tail = TAIL_BAD_SUM;
          1:       tail = TAIL_NO_STAR;
          2:       tail = TAIL_ONE_DIGIT;
          3:       tail = TAIL_BAD_DIGIT;
          4:       tail = TAIL_EXTRA;
          default: tail = TAIL_GOOD;
        endcase
        make_sentence($urandom_range(0, nsc_pkg::NUM_TYPES - 1), $urandom_range(0, 24),
                      tail, 1'b0);
      end else if (sel < 78) begin
        repeat ($urandom_range(1, 10)) tx_q.push_back(8'($urandom_range(0, 255)));
      end else if (sel < 83) begin
        make_sentence(nsc_pkg::NUM_TYPES, $urandom_range(0, 12), TAIL_GOOD, 1'b0);
      end else if (sel < 87) begin
        // cut short inside or right after the type, then CR
        make_sentence($urandom_range(0, nsc_pkg::NUM_TYPES - 1), 0, TAIL_GOOD, 1'b0);
        cut = $urandom_range(1, nsc_pkg::TYPE_LEN + 1);
        while (tx_q.size() > cut) void'(tx_q.pop_back());
        tx_q.push_back(nsc_pkg::CH_CR);
      end else if (sel < 91) begin
        // cut anywhere; the next sentence's dollar restarts it
        make_sentence($urandom_range(0, nsc_pkg::NUM_TYPES - 1), $urandom_range(0, 16),
                      TAIL_GOOD, 1'b0);
        cut = $urandom_range(1, tx_q.size() - 2);
        while (tx_q.size() > cut) void'(tx_q.pop_back());
      end else if (sel < 94) begin
        make_sentence($urandom_range(0, nsc_pkg::NUM_TYPES - 1), $urandom_range(0, 16),
                      TAIL_GOOD, 1'b1);
      end else if (sel < 97) begin
        make_sentence($urandom_range(0, nsc_pkg::NUM_TYPES - 1), $urandom_range(110, 125),
                      $urandom_range(0, 1) ? TAIL_GOOD : TAIL_NO_STAR, 1'b0);
      end else begin
        tx_q.push_back(CH_LF);
        tx_q.push_back(8'($urandom_range(0, 255)));
      end
      send_queue();
      iter++;
      if (iter == 40) drain_results();
    end

    // Let every outstanding result out, then a few more cycles for strays.
    in_valid <= 1'b0;
    spins = 0;
    while (sb.pending_q.size() != 0 && spins < 20000) begin
      @(posedge clk);
      spins++;
    end
    repeat (8) @(posedge clk);
    if (sb.pending_q.size() != 0)
      sb.report_mismatch($sformatf("%0d expected results never came out",
                                   sb.pending_q.size()));

    $display("run covered %0d bytes (%0d inside sentences) and %0d checked results",
             sb.total_bytes, sb.live_bytes, sb.checked);
    $display("with %0d mismatches", sb.errors);
    if (sb.errors == 0) begin
      $display("** nmea_sentence_checker: PASSED **");
    end else begin
      $display("** nmea_sentence_checker: FAILED **");
    end
    $finish;
  end

endmodule
